/* design/bpc_pkg.sv */
// Shared widths, constants and register codes for the brush pixel compositor.
`default_nettype none
package bpc_pkg;

  // Coordinate format and canvas extent
  localparam int COORD_FRAC_BITS = 4;
  localparam int CANVAS_SIZE     = 4096;
  localparam int UP              = 16 - COORD_FRAC_BITS;
  localparam int HALF_LSB        = 1 << (COORD_FRAC_BITS - 1);

  // Field widths
  localparam int XY_W     = 12;
  localparam int CENTER_W = 18;
  localparam int PRESS_W  = 13;
  localparam int RAD_W    = 12;
  localparam int PIX_W    = 32;
  localparam int CFG_W    = 32;
  localparam int IDX_W    = 2;

  // Distance datapath
  localparam int PC_W    = XY_W + COORD_FRAC_BITS;
  localparam int DIFF_W  = ((PC_W > CENTER_W) ? PC_W : CENTER_W) + 1;
  localparam int ABS_W   = DIFF_W - 1;
  localparam int SQ_W    = 2 * ABS_W;
  localparam int SUM_W   = SQ_W + 1;
  localparam int PROD_W  = RAD_W + PRESS_W;
  localparam int RADQ_W  = PROD_W + UP - 12;
  localparam int ROOT_W  = RADQ_W;
  localparam int ARG_W   = 2 * ROOT_W;
  localparam int FAR_BIT = ARG_W - 2 * UP;

  // Coverage and compositing
  localparam int COV_W       = 17;
  localparam int Q16_ONE     = 65536;
  localparam int Q16_HALF    = 32768;
  localparam int PRESS_ONE   = 4096;
  localparam int PRESS_FLOOR = 205;
  localparam int KSCALE      = 255 * 65536;
  localparam int SA_W        = 25;
  localparam int NUMV_W      = 41;
  localparam int N_W         = 33;
  localparam int NUM_W       = 42;
  localparam int DEN_W       = 34;
  localparam int QUO_W       = 8;

  // Output alpha: floor(y / 255) = (y * ALPHA_RECIP) >> ALPHA_SHIFT for 16-bit y
  localparam int ALPHA_RECIP = 32897;
  localparam int ALPHA_SHIFT = 23;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_BRUSH_RADIUS   = 2'd0,
    REG_PRESSURE_SCALE = 2'd1,
    REG_BRUSH_COLOR    = 2'd2,
    REG_ERASE_MODE     = 2'd3
  } reg_index_t;

endpackage
`default_nettype wire

/* design/bpc_item_if.sv */
// Input channel carrying one canvas pixel and dab description per transaction.
`default_nettype none
interface bpc_item_if;
  logic                                 valid;
  logic                                 ready;
  logic [bpc_pkg::XY_W-1:0]             pixel_x;
  logic [bpc_pkg::XY_W-1:0]             pixel_y;
  logic [bpc_pkg::PIX_W-1:0]            dst_pixel;
  logic signed [bpc_pkg::CENTER_W-1:0]  center_x;
  logic signed [bpc_pkg::CENTER_W-1:0]  center_y;
  logic [bpc_pkg::PRESS_W-1:0]          pen_pressure;

  modport source (
    output valid, pixel_x, pixel_y, dst_pixel, center_x, center_y, pen_pressure,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, dst_pixel, center_x, center_y, pen_pressure,
    output ready
  );
endinterface
`default_nettype wire

/* design/bpc_result_if.sv */
// Output channel carrying one composited pixel per transaction.
`default_nettype none
interface bpc_result_if;
  logic                       valid;
  logic                       ready;
  logic [bpc_pkg::PIX_W-1:0]  new_pixel;
  logic                       touched;

  modport source (output valid, new_pixel, touched, input ready);
  modport sink   (input valid, new_pixel, touched, output ready);
endinterface
`default_nettype wire

/* design/brush_pixel_compositor_core.sv */
// Brush dab compositor top level: coverage, erase and src-over pipeline.
// Throughput: one pixel per cycle while the output skid register is empty.
// The 25-stage square root and 8-stage dividers are pipelined.
// Backpressure freezes the whole pipeline only once the output skid register is full.
// Reset (rst, synchronous): clears all valid bits and loads the register reset values.
`default_nettype none
module brush_pixel_compositor_core (
  input  logic                        clk,
  input  logic                        rst,
  bpc_item_if.sink                    item,
  bpc_result_if.source                result,
  input  logic                        wr_en,
  input  logic [bpc_pkg::IDX_W-1:0]   wr_index,
  input  logic [bpc_pkg::CFG_W-1:0]   wr_data
);
  localparam int F        = bpc_pkg::COORD_FRAC_BITS;
  localparam int UP       = bpc_pkg::UP;
  localparam int XY_W     = bpc_pkg::XY_W;
  localparam int CENTER_W = bpc_pkg::CENTER_W;
  localparam int PRESS_W  = bpc_pkg::PRESS_W;
  localparam int RAD_W    = bpc_pkg::RAD_W;
  localparam int PIX_W    = bpc_pkg::PIX_W;
  localparam int PC_W     = bpc_pkg::PC_W;
  localparam int DIFF_W   = bpc_pkg::DIFF_W;
  localparam int ABS_W    = bpc_pkg::ABS_W;
  localparam int SQ_W     = bpc_pkg::SQ_W;
  localparam int SUM_W    = bpc_pkg::SUM_W;
  localparam int PROD_W   = bpc_pkg::PROD_W;
  localparam int RADQ_W   = bpc_pkg::RADQ_W;
  localparam int ROOT_W   = bpc_pkg::ROOT_W;
  localparam int ARG_W    = bpc_pkg::ARG_W;
  localparam int FAR_BIT  = bpc_pkg::FAR_BIT;
  localparam int COV_W    = bpc_pkg::COV_W;
  localparam int SA_W     = bpc_pkg::SA_W;
  localparam int NUMV_W   = bpc_pkg::NUMV_W;
  localparam int N_W      = bpc_pkg::N_W;
  localparam int NUM_W    = bpc_pkg::NUM_W;
  localparam int DEN_W    = bpc_pkg::DEN_W;
  localparam int QUO_W    = bpc_pkg::QUO_W;
  localparam int T_W      = ROOT_W + 2;
  localparam int RSUM_W   = PROD_W + UP + 1;
  localparam int LANES    = 3;
  localparam int AY_W     = N_W - 16;
  localparam int AM_W     = AY_W + 16;

  typedef struct packed {
    logic [PIX_W-1:0]  dst;
    logic              live;
    logic [RADQ_W-1:0] radq;
  } sq_sb_t;

  typedef struct packed {
    logic [PIX_W-1:0] dst;
    logic             hit;
    logic [7:0]       a_er;
    logic [7:0]       a_pt;
    logic             nz;
  } dv_sb_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             touched;
  } out_t;

  // Configuration registers
  logic [RAD_W-1:0] brush_radius;
  logic             pressure_scales;
  logic [PIX_W-1:0] brush_color;
  logic             erase_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      brush_radius    <= RAD_W'(64);
      pressure_scales <= 1'b0;
      brush_color     <= 32'hFF00_0000;
      erase_mode      <= 1'b0;
    end else if (wr_en) begin
      unique case (bpc_pkg::reg_index_t'(wr_index))
        bpc_pkg::REG_BRUSH_RADIUS:   brush_radius    <= wr_data[RAD_W-1:0];
        bpc_pkg::REG_PRESSURE_SCALE: pressure_scales <= wr_data[0];
        bpc_pkg::REG_BRUSH_COLOR:    brush_color     <= wr_data[PIX_W-1:0];
        bpc_pkg::REG_ERASE_MODE:     erase_mode      <= wr_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: stall everything only while the skid register holds
  logic en;
  logic skid_v;
  assign en         = !skid_v;
  assign item.ready = en;

  // Valid bits for all stages
  logic              v1, v2, v3, v4, v5, v6, v7, v8, v9, v10;
  logic [ROOT_W-1:0] sq_v;
  logic [QUO_W-1:0]  dv_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10} <= '0;
      sq_v <= '0;
      dv_v <= '0;
    end else if (en) begin
      v1   <= item.valid;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      sq_v <= {sq_v[ROOT_W-2:0], v4};
      v5   <= sq_v[ROOT_W-1];
      v6   <= v5;
      v7   <= v6;
      v8   <= v7;
      v9   <= v8;
      v10  <= v9;
      dv_v <= {dv_v[QUO_W-2:0], v10};
    end
  end

  // Stage 1: capture the transaction
  logic [XY_W-1:0]            px1, py1;
  logic [PIX_W-1:0]           dst1;
  logic signed [CENTER_W-1:0] cx1, cy1;
  logic [PRESS_W-1:0]         p1;

  always_ff @(posedge clk) begin
    if (en) begin
      px1  <= item.pixel_x;
      py1  <= item.pixel_y;
      dst1 <= item.dst_pixel;
      cx1  <= item.center_x;
      cy1  <= item.center_y;
      p1   <= item.pen_pressure;
    end
  end

  // Stage 2: clamp pressure (or force it to full scale when scaling is off), offsets from the pixel center
  logic [PRESS_W-1:0]       p_eff;
  logic [PC_W-1:0]          pcx, pcy;
  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]        ndx, ndy;
  logic                     on_c;

  always_comb begin
    if (pressure_scales) begin
      if (p1 > PRESS_W'(bpc_pkg::PRESS_ONE)) begin
        p_eff = PRESS_W'(bpc_pkg::PRESS_ONE);
      end else if (p1 < PRESS_W'(bpc_pkg::PRESS_FLOOR)) begin
        p_eff = PRESS_W'(bpc_pkg::PRESS_FLOOR);
      end else begin
        p_eff = p1;
      end
    end else begin
      p_eff = PRESS_W'(bpc_pkg::PRESS_ONE);
    end
  end

  assign pcx  = {px1, {F{1'b0}}} | PC_W'(bpc_pkg::HALF_LSB);
  assign pcy  = {py1, {F{1'b0}}} | PC_W'(bpc_pkg::HALF_LSB);
  assign dx   = $signed({{(DIFF_W - PC_W){1'b0}}, pcx}) -
                $signed({{(DIFF_W - CENTER_W){cx1[CENTER_W-1]}}, cx1});
  assign dy   = $signed({{(DIFF_W - PC_W){1'b0}}, pcy}) -
                $signed({{(DIFF_W - CENTER_W){cy1[CENTER_W-1]}}, cy1});
  assign ndx  = -dx;
  assign ndy  = -dy;
  assign on_c = (32'(px1) < 32'(bpc_pkg::CANVAS_SIZE)) &&
                (32'(py1) < 32'(bpc_pkg::CANVAS_SIZE));

  logic [PRESS_W-1:0] p2;
  logic [ABS_W-1:0]   adx2, ady2;
  logic               on2;
  logic [PIX_W-1:0]   dst2;

  always_ff @(posedge clk) begin
    if (en) begin
      p2   <= p_eff;
      adx2 <= dx[DIFF_W-1] ? ndx[ABS_W-1:0] : dx[ABS_W-1:0];
      ady2 <= dy[DIFF_W-1] ? ndy[ABS_W-1:0] : dy[ABS_W-1:0];
      on2  <= on_c;
      dst2 <= dst1;
    end
  end

  // Stage 3: radius product and squared offsets
  logic [PROD_W-1:0] prod3;
  logic [SQ_W-1:0]   sqx3, sqy3;
  logic              on3;
  logic [PIX_W-1:0]  dst3;

  always_ff @(posedge clk) begin
    if (en) begin
      prod3 <= PROD_W'(brush_radius) * PROD_W'(p2);
      sqx3  <= SQ_W'(adx2) * SQ_W'(adx2);
      sqy3  <= SQ_W'(ady2) * SQ_W'(ady2);
      on3   <= on2;
      dst3  <= dst2;
    end
  end

  // Stage 4: radius in Q16, squared distance, far-away test
  logic [SUM_W-1:0]  sum_c;
  logic [RSUM_W-1:0] rsum_c;
  logic [ARG_W-1:0]  arg4;
  sq_sb_t            sb4;

  assign sum_c  = SUM_W'(sqx3) + SUM_W'(sqy3);
  assign rsum_c = RSUM_W'({prod3, {UP{1'b0}}}) + RSUM_W'(2048);

  always_ff @(posedge clk) begin
    if (en) begin
      arg4      <= {sum_c[FAR_BIT-1:0], {(2 * UP){1'b0}}};
      sb4.dst   <= dst3;
      sb4.live  <= on3 && (sum_c[SUM_W-1:FAR_BIT] == '0);
      sb4.radq  <= rsum_c[PROD_W+UP-1:12];
    end
  end

  // Square root of the scaled squared distance
  logic [ROOT_W-1:0] root;
  sq_sb_t            sq_sb [0:ROOT_W-1];

  bpc_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .arg  (arg4),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sq_sb[0] <= sb4;
      for (int i = 1; i < ROOT_W; i++) begin
        sq_sb[i] <= sq_sb[i-1];
      end
    end
  end

  // Stage 5: coverage = clamp(radius + 1/2 - distance, 0, 1)
  sq_sb_t                sq_last;
  logic signed [T_W-1:0] t_c;
  logic [COV_W-1:0]      cov5;
  logic                  hit5;
  logic [PIX_W-1:0]      dst5;

  assign sq_last = sq_sb[ROOT_W-1];
  assign t_c = $signed({2'b00, sq_last.radq}) + $signed(T_W'(bpc_pkg::Q16_HALF)) -
               $signed({2'b00, root});

  always_ff @(posedge clk) begin
    if (en) begin
      hit5 <= sq_last.live && !t_c[T_W-1] && (t_c != '0);
      cov5 <= (t_c > $signed(T_W'(bpc_pkg::Q16_ONE))) ? COV_W'(bpc_pkg::Q16_ONE)
                                                      : t_c[COV_W-1:0];
      dst5 <= sq_last.dst;
    end
  end

  // Stage 6: brush alpha times coverage, erase product, dst color times dst alpha
  logic [SA_W-1:0]  sa6, ea6;
  logic [15:0]      dd6 [0:2];
  logic             hit6;
  logic [PIX_W-1:0] dst6;

  always_ff @(posedge clk) begin
    if (en) begin
      sa6  <= SA_W'(brush_color[31:24]) * SA_W'(cov5);
      ea6  <= SA_W'(dst5[31:24]) * (SA_W'(bpc_pkg::Q16_ONE) - SA_W'(cov5));
      for (int c = 0; c < 3; c++) begin
        dd6[c] <= 16'(dst5[8*c +: 8]) * 16'(dst5[31:24]);
      end
      hit6 <= hit5;
      dst6 <= dst5;
    end
  end

  // Stage 7: complement of source alpha, rounded erase alpha
  logic [SA_W-1:0]  sa7, ksa7;
  logic [SA_W:0]    ea_rnd;
  logic [7:0]       aer7;
  logic [15:0]      dd7 [0:2];
  logic             hit7;
  logic [PIX_W-1:0] dst7;

  assign ea_rnd = (SA_W + 1)'(ea6) + (SA_W + 1)'(bpc_pkg::Q16_HALF);

  always_ff @(posedge clk) begin
    if (en) begin
      sa7  <= sa6;
      ksa7 <= SA_W'(bpc_pkg::KSCALE) - sa6;
      aer7 <= ea_rnd[23:16];
      dd7  <= dd6;
      hit7 <= hit6;
      dst7 <= dst6;
    end
  end

  // Stage 8: per-channel source and destination products
  logic [N_W-1:0]    ms8 [0:2];
  logic [NUMV_W-1:0] md8 [0:2];
  logic [N_W-1:0]    nd8, sa8;
  logic [7:0]        aer8;
  logic              hit8;
  logic [PIX_W-1:0]  dst8;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        ms8[c] <= N_W'(brush_color[8*c +: 8]) * N_W'(sa7);
        md8[c] <= NUMV_W'(dd7[c]) * NUMV_W'(ksa7);
      end
      nd8  <= N_W'(dst7[31:24]) * N_W'(ksa7);
      sa8  <= N_W'(sa7);
      aer8 <= aer7;
      hit8 <= hit7;
      dst8 <= dst7;
    end
  end

  // Stage 9: channel numerators and the output alpha numerator
  logic [NUMV_W-1:0] num9 [0:2];
  logic [N_W-1:0]    n9;
  logic [7:0]        aer9;
  logic              hit9;
  logic [PIX_W-1:0]  dst9;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        num9[c] <= (NUMV_W'(ms8[c]) << 8) - NUMV_W'(ms8[c]) + md8[c];
      end
      n9   <= (sa8 << 8) - sa8 + nd8;
      aer9 <= aer8;
      hit9 <= hit8;
      dst9 <= dst8;
    end
  end

  // Stage 10: round-half-up dividends and divisors for the color lanes;
  // output alpha is round(n / K) = floor(((n + K/2) >> 16) / 255) by reciprocal
  logic [NUM_W-1:0] dvd10 [0:LANES-1];
  logic [DEN_W-1:0] dvs10 [0:LANES-1];
  dv_sb_t           sb10;
  logic [N_W-1:0]   ax_c;
  logic [AY_W-1:0]  ay_c;
  logic [AM_W-1:0]  am_c;

  assign ax_c = n9 + N_W'(bpc_pkg::KSCALE / 2);
  assign ay_c = ax_c[N_W-1:16];
  assign am_c = AM_W'(ay_c) * AM_W'(bpc_pkg::ALPHA_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < LANES; c++) begin
        dvd10[c] <= {num9[c], 1'b0} + NUM_W'(n9);
        dvs10[c] <= {n9, 1'b0};
      end
      sb10.dst  <= dst9;
      sb10.hit  <= hit9;
      sb10.a_er <= aer9;
      sb10.a_pt <= am_c[bpc_pkg::ALPHA_SHIFT +: 8];
      sb10.nz   <= (n9 != '0);
    end
  end

  // Color dividers
  logic [QUO_W-1:0] quo [0:LANES-1];

  for (genvar c = 0; c < LANES; c++) begin : g_lane
    bpc_div u_div (
      .clk      (clk),
      .en       (en),
      .dividend (dvd10[c]),
      .divisor  (dvs10[c]),
      .quotient (quo[c])
    );
  end

  dv_sb_t dv_sb [0:QUO_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_sb[0] <= sb10;
      for (int i = 1; i < QUO_W; i++) begin
        dv_sb[i] <= dv_sb[i-1];
      end
    end
  end

  // Assemble the result pixel
  dv_sb_t dv_last;
  out_t   fin;

  assign dv_last = dv_sb[QUO_W-1];

  always_comb begin
    if (!dv_last.hit) begin
      fin.pixel = dv_last.dst;
    end else if (erase_mode) begin
      fin.pixel = {dv_last.a_er, dv_last.dst[23:0]};
    end else if (dv_last.nz) begin
      fin.pixel = {dv_last.a_pt, quo[2], quo[1], quo[0]};
    end else begin
      fin.pixel = {dv_last.a_pt, dv_last.dst[23:0]};
    end
    fin.touched = (fin.pixel != dv_last.dst);
  end

  // Output register with skid stage
  logic out_v;
  out_t out_q, skid_q;
  logic last_v;
  assign last_v = dv_v[QUO_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (result.ready) begin
        skid_v <= 1'b0;
      end
    end else if (out_v && !result.ready) begin
      skid_v <= last_v;
    end else begin
      out_v <= last_v;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (result.ready) begin
        out_q <= skid_q;
      end
    end else if (out_v && !result.ready) begin
      skid_q <= fin;
    end else begin
      out_q <= fin;
    end
  end

  assign result.valid     = out_v;
  assign result.new_pixel = out_q.pixel;
  assign result.touched   = out_q.touched;

`ifndef SYNTHESIS
  // Skid register holds data only behind a full output register
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid register full while output register empty");

  // Skid register fills only when the output was stalled
  a_skid_fill : assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(out_v && !result.ready))
    else $error("skid register filled without a stalled output");

  // A stalled pipeline keeps its last stage
  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(last_v))
    else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire

/* design/bpc_sqrt.sv */
// Pipelined integer square root, one root bit resolved per stage.
`default_nettype none
module bpc_sqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [bpc_pkg::ARG_W-1:0]    arg,
  output logic [bpc_pkg::ROOT_W-1:0]   root
);
  localparam int ARG_W  = bpc_pkg::ARG_W;
  localparam int ROOT_W = bpc_pkg::ROOT_W;

  logic [ARG_W-1:0]  rem_r  [0:ROOT_W-2];
  logic [ROOT_W-1:0] root_r [0:ROOT_W-1];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_step
    localparam int K = ROOT_W - 1 - s;
    logic [ARG_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [ARG_W:0]    term;
    logic              take;

    // Pick up the previous stage, or the operand at the head
    if (s == 0) begin : g_head
      assign rem_in  = arg;
      assign root_in = '0;
    end else begin : g_body
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
    end

    // Trial subtract of (2*root + 2^K) * 2^K
    assign term = ({{(ARG_W + 1 - ROOT_W){1'b0}}, root_in} << (K + 1)) |
                  ((ARG_W + 1)'(1) << (2 * K));
    assign take = {1'b0, rem_in} >= term;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[s] <= take ? (root_in | (ROOT_W'(1) << K)) : root_in;
      end
    end

    if (s < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= take ? (rem_in - term[ARG_W-1:0]) : rem_in;
        end
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule
`default_nettype wire

/* design/bpc_div.sv */
// Pipelined restoring divider, one quotient bit resolved per stage.
`default_nettype none
module bpc_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [bpc_pkg::NUM_W-1:0]   dividend,
  input  logic [bpc_pkg::DEN_W-1:0]   divisor,
  output logic [bpc_pkg::QUO_W-1:0]   quotient
);
  localparam int NUM_W = bpc_pkg::NUM_W;
  localparam int DEN_W = bpc_pkg::DEN_W;
  localparam int QUO_W = bpc_pkg::QUO_W;

  logic [NUM_W-1:0] rem_r [0:QUO_W-2];
  logic [DEN_W-1:0] den_r [0:QUO_W-2];
  logic [QUO_W-1:0] quo_r [0:QUO_W-1];

  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    localparam int K = QUO_W - 1 - s;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [NUM_W-1:0] term;
    logic             take;

    if (s == 0) begin : g_head
      assign rem_in = dividend;
      assign den_in = divisor;
      assign quo_in = '0;
    end else begin : g_body
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    // Compare against the divisor aligned to this quotient bit
    assign term = NUM_W'(den_in) << K;
    assign take = rem_in >= term;

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[s] <= take ? (quo_in | (QUO_W'(1) << K)) : quo_in;
      end
    end

    if (s < QUO_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= take ? (rem_in - term) : rem_in;
          den_r[s] <= den_in;
        end
      end
    end
  end

  assign quotient = quo_r[QUO_W-1];

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the brush pixel compositor: directed and random pixels.
`default_nettype none
module testbench;

  typedef struct packed {
    logic [bpc_pkg::PIX_W-1:0] new_pixel;
    logic                      touched;
  } pixel_out_t;

  logic clk;
  logic rst;
  logic wr_en;
  logic [bpc_pkg::IDX_W-1:0] wr_index;
  logic [bpc_pkg::CFG_W-1:0] wr_data;

  bpc_item_if   item_ch ();
  bpc_result_if result_ch ();

  brush_pixel_compositor_core dut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (result_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Local copy of the brush settings
  logic [bpc_pkg::RAD_W-1:0] cur_radius;
  logic                      cur_press_scale;
  logic [31:0]               cur_color;
  logic                      cur_erase;

  pixel_out_t expected_pixels[$];
  int unsigned errors;
  int unsigned burst_left;
  int unsigned hold_cycles;
  int unsigned stall_level;
  int unsigned stall_count;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Time limit
  initial begin
    #30000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Compute the composited pixel for the current brush settings
  function automatic pixel_out_t composite_pixel(
    logic [bpc_pkg::XY_W-1:0] px, logic [bpc_pkg::XY_W-1:0] py, logic [31:0] dst,
    logic signed [bpc_pkg::CENTER_W-1:0] cx, logic signed [bpc_pkg::CENTER_W-1:0] cy,
    logic [bpc_pkg::PRESS_W-1:0] press);
    pixel_out_t o;
    longint unsigned p, radq, sum, dist_q16, cov, adx, ady, a, sa, da, n, s, d, num, v;
    longint unsigned kscale;
    longint dx, dy, t;
    logic [31:0] res;
    kscale = 64'd255 * 64'd65536;
    o.new_pixel = dst;
    o.touched = 1'b0;
    if (px >= bpc_pkg::CANVAS_SIZE || py >= bpc_pkg::CANVAS_SIZE) return o;
    p = press;
    if (cur_press_scale) begin
      if (p > bpc_pkg::PRESS_ONE) p = bpc_pkg::PRESS_ONE;
      if (p < bpc_pkg::PRESS_FLOOR) p = bpc_pkg::PRESS_FLOOR;
    end else begin
      p = bpc_pkg::PRESS_ONE;
    end
    radq = (((longint'(cur_radius) * p) << bpc_pkg::UP) + 2048) >> 12;
    dx = longint'((px << bpc_pkg::COORD_FRAC_BITS) + bpc_pkg::HALF_LSB) - longint'(cx);
    dy = longint'((py << bpc_pkg::COORD_FRAC_BITS) + bpc_pkg::HALF_LSB) - longint'(cy);
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    sum = adx * adx + ady * ady;
    if ((sum >> (64 - 2 * bpc_pkg::UP)) != 0) return o;
    dist_q16 = int_sqrt(sum << (2 * bpc_pkg::UP));
    t = longint'(radq) + bpc_pkg::Q16_HALF - longint'(dist_q16);
    if (t <= 0) return o;
    cov = (t > bpc_pkg::Q16_ONE) ? bpc_pkg::Q16_ONE : t;
    if (cur_erase) begin
      a = dst[31:24];
      a = (a * (bpc_pkg::Q16_ONE - cov) + bpc_pkg::Q16_HALF) >> 16;
      res = {a[7:0], dst[23:0]};
    end else begin
      sa = longint'(cur_color[31:24]) * cov;
      da = dst[31:24];
      n = 255 * sa + da * (kscale - sa);
      res = {8'd0, dst[23:0]};
      if (n != 0) begin
        for (int sh = 0; sh < 24; sh += 8) begin
          s = (cur_color >> sh) & 8'hFF;
          d = (dst >> sh) & 8'hFF;
          num = s * 255 * sa + d * da * (kscale - sa);
          v = (2 * num + n) / (2 * n);
          if (v > 255) v = 255;
          res[sh +: 8] = v[7:0];
        end
      end
      a = (2 * n + kscale) / (2 * kscale);
      if (a > 255) a = 255;
      res[31:24] = a[7:0];
    end
    o.new_pixel = res;
    o.touched = (res != dst);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // Receiver: stall pattern, long hold-offs, and result checking
  always @(posedge clk) begin
    pixel_out_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected result", result_ch.new_pixel, 32'd0);
        end else begin
          want = expected_pixels.pop_front();
          if (result_ch.new_pixel !== want.new_pixel)
            report_mismatch("new_pixel", result_ch.new_pixel, want.new_pixel);
          if (result_ch.touched !== want.touched)
            report_mismatch("touched", 32'(result_ch.touched), 32'(want.touched));
        end
      end
      stall_count++;
      if (stall_count % 80 == 0) stall_level = $urandom_range(0, 3);
      if (hold_cycles > 0) begin
        hold_cycles--;
        result_ch.ready <= 1'b0;
      end else if (stall_level == 0) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= ($urandom_range(0, 3) >= stall_level);
      end
    end
  end

  // Offer one pixel and hold it until accepted, then maybe open a gap
  task automatic send_pixel(logic [bpc_pkg::XY_W-1:0] px, logic [bpc_pkg::XY_W-1:0] py,
                            logic [31:0] dst,
                            logic signed [bpc_pkg::CENTER_W-1:0] cx,
                            logic signed [bpc_pkg::CENTER_W-1:0] cy,
                            logic [bpc_pkg::PRESS_W-1:0] press);
    int unsigned gap;
    item_ch.valid        <= 1'b1;
    item_ch.pixel_x      <= px;
    item_ch.pixel_y      <= py;
    item_ch.dst_pixel    <= dst;
    item_ch.center_x     <= cx;
    item_ch.center_y     <= cy;
    item_ch.pen_pressure <= press;
    do @(posedge clk); while (!item_ch.ready);
    expected_pixels.push_back(composite_pixel(px, py, dst, cx, cy, press));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Random pixel, mostly placed near the dab edge so coverage varies
  task automatic send_random_pixel();
    logic [bpc_pkg::XY_W-1:0] px, py;
    int span;
    logic signed [bpc_pkg::CENTER_W-1:0] cx, cy;
    px = bpc_pkg::XY_W'($urandom_range(0, 4095));
    py = bpc_pkg::XY_W'($urandom_range(0, 4095));
    if ($urandom_range(0, 9) == 0) begin
      cx = bpc_pkg::CENTER_W'($urandom);
      cy = bpc_pkg::CENTER_W'($urandom);
    end else begin
      span = cur_radius + 48;
      cx = bpc_pkg::CENTER_W'((px * 16 + 8) + $urandom_range(0, 2 * span) - span);
      cy = bpc_pkg::CENTER_W'((py * 16 + 8) + $urandom_range(0, 2 * span) - span);
    end
    send_pixel(px, py, $urandom, cx, cy, bpc_pkg::PRESS_W'($urandom_range(0, 8191)));
  endtask

  // Stop offering and wait until every result is back and the pipe is empty
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Write all brush registers; only call when drained
  task automatic write_brush(logic [bpc_pkg::RAD_W-1:0] radius, logic scale,
                             logic [31:0] color, logic erase);
    bpc_pkg::reg_index_t idx;
    logic [bpc_pkg::CFG_W-1:0] vals[4];
    vals[0] = bpc_pkg::CFG_W'(radius);
    vals[1] = bpc_pkg::CFG_W'(scale);
    vals[2] = color;
    vals[3] = bpc_pkg::CFG_W'(erase);
    for (int i = 0; i < 4; i++) begin
      idx = bpc_pkg::reg_index_t'(i);
      wr_en    <= 1'b1;
      wr_index <= idx;
      wr_data  <= vals[i];
      @(posedge clk);
    end
    wr_en <= 1'b0;
    cur_radius      = radius;
    cur_press_scale = scale;
    cur_color       = color;
    cur_erase       = erase;
  endtask

  task automatic test_reset_defaults();
    send_pixel(12'd10, 12'd10, 32'h0000_0000, 18'sd168, 18'sd168, 13'd4096);
    send_pixel(12'd10, 12'd10, 32'h80FF_FFFF, 18'sd170, 18'sd160, 13'd0);
    send_pixel(12'd14, 12'd10, 32'h1234_5678, 18'sd168, 18'sd168, 13'd4096);
    wait_drained();
  endtask

  task automatic test_directed_extremes();
    write_brush(12'd4095, 1'b1, 32'hFFFF_FFFF, 1'b0);
    send_pixel(12'd0, 12'd0, 32'h0000_0000, 18'sd8, 18'sd8, 13'd8191);
    send_pixel(12'd4095, 12'd4095, 32'hFFFF_FFFF, 18'sd65528, 18'sd65528, 13'd4096);
    send_pixel(12'd4095, 12'd0, 32'hFF00_00FF, 18'sd65000, 18'sd100, 13'd4097);
    send_pixel(12'd100, 12'd100, 32'h7F3C_2A11, 18'sd1608, 18'sd1608, 13'd0);
    send_pixel(12'd100, 12'd100, 32'h7F3C_2A11, 18'sd1608, 18'sd1608, 13'd204);
    send_pixel(12'd100, 12'd100, 32'h7F3C_2A11, 18'sd1608, 18'sd1608, 13'd205);
    send_pixel(12'd0, 12'd4095, 32'h8080_8080, -18'sd131072, 18'sd131071, 13'd4096);
    send_pixel(12'd4095, 12'd4095, 32'h0102_0304, -18'sd131072, -18'sd131072, 13'd4096);
    wait_drained();
    // transparent brush over transparent pixel keeps the color bytes
    write_brush(12'd32, 1'b0, 32'h00AB_CDEF, 1'b0);
    send_pixel(12'd5, 12'd5, 32'h0011_2233, 18'sd88, 18'sd88, 13'd4096);
    send_pixel(12'd5, 12'd5, 32'h0111_2233, 18'sd88, 18'sd88, 13'd4096);
    wait_drained();
    // zero radius: only the half-pixel fringe covers
    write_brush(12'd0, 1'b0, 32'h80C0_4020, 1'b0);
    send_pixel(12'd5, 12'd5, 32'hFF00_0000, 18'sd88, 18'sd88, 13'd4096);
    send_pixel(12'd5, 12'd5, 32'hFF00_0000, 18'sd95, 18'sd88, 13'd4096);
    send_pixel(12'd5, 12'd5, 32'hFF00_0000, 18'sd120, 18'sd88, 13'd4096);
    wait_drained();
    // erase at full and partial coverage
    write_brush(12'd40, 1'b1, 32'h0000_0000, 1'b1);
    send_pixel(12'd20, 12'd20, 32'hFF12_3456, 18'sd328, 18'sd328, 13'd4096);
    send_pixel(12'd20, 12'd20, 32'hFF12_3456, 18'sd360, 18'sd328, 13'd4096);
    send_pixel(12'd20, 12'd20, 32'h00FF_FFFF, 18'sd328, 18'sd328, 13'd50);
    send_pixel(12'd20, 12'd20, 32'hFFFF_FFFF, -18'sd131072, 18'sd328, 13'd4096);
    wait_drained();
  endtask

  task automatic test_random_settings();
    logic [bpc_pkg::RAD_W-1:0] radius;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: radius = 12'd0;
        1: radius = 12'd4095;
        default: radius = bpc_pkg::RAD_W'($urandom_range(0, 600));
      endcase
      write_brush(radius, phase[0], $urandom, phase[1]);
      repeat (110) send_random_pixel();
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    write_brush(12'd200, 1'b1, 32'hC040_80F0, 1'b0);
    hold_cycles = 400;
    repeat (150) send_random_pixel();
    wait_drained();
    write_brush(12'd90, 1'b0, 32'h7FFF_0000, 1'b1);
    repeat (120) send_random_pixel();
    wait_drained();
  endtask

  initial begin
    errors = 0;
    burst_left = 0;
    hold_cycles = 0;
    stall_level = 0;
    stall_count = 0;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    item_ch.valid = 1'b0;
    item_ch.pixel_x = '0;
    item_ch.pixel_y = '0;
    item_ch.dst_pixel = '0;
    item_ch.center_x = '0;
    item_ch.center_y = '0;
    item_ch.pen_pressure = '0;
    result_ch.ready = 1'b0;
    cur_radius = 12'd64;
    cur_press_scale = 1'b0;
    cur_color = 32'hFF00_0000;
    cur_erase = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_directed_extremes();
    test_random_settings();
    test_backpressure();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* brush_pixel_compositor_core.f */
design/bpc_pkg.sv
design/bpc_item_if.sv
design/bpc_result_if.sv
design/bpc_sqrt.sv
design/bpc_div.sv
design/brush_pixel_compositor_core.sv
tb/testbench.sv
